// ===== rtl/core/heat_value_colorizer_unit_assert.svh =====
// Assertion macros for the colouriser checker
`ifndef HEAT_VALUE_COLORIZER_UNIT_ASSERT_SVH
`define HEAT_VALUE_COLORIZER_UNIT_ASSERT_SVH

// checked only out of reset
`define HVC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hvc assertion failed");

// checked at every edge, reset included
`define HVC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hvc assertion failed");

`endif

// ===== rtl/core/hvc_pkg.sv =====
// Types, constants and colour table of the heat value colouriser
package hvc_pkg;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned T_W      = 17;  // Q1.16, 65536 is one
  localparam int unsigned DIV_STEPS = 17; // one quotient bit per stage
  localparam int unsigned NUM_W    = 32;  // opacity dividend
  localparam int unsigned DSH_W    = 40;  // shifted opacity divisor
  localparam int unsigned STOPS    = 8;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic signed [VAL_W-1:0] VAL_MIN_RST = -16'sd1760;
  localparam logic signed [VAL_W-1:0] VAL_MAX_RST = -16'sd1280;
  localparam logic [RADIUS_W-1:0]     RADIUS_RST  = 23'd1280;

  localparam logic [CH_W-1:0] ALPHA_FAR = 8'd52;

  // stop positions in twentieths
  localparam logic [4:0] STOP_POS [STOPS] = '{5'd0, 5'd3, 5'd6, 5'd9,
                                              5'd12, 5'd15, 5'd18, 5'd20};
  localparam logic [CH_W-1:0] STOP_RED [STOPS] = '{8'd48, 8'd40, 8'd20, 8'd90,
                                                   8'd220, 8'd251, 8'd200, 8'd122};
  localparam logic [CH_W-1:0] STOP_GRN [STOPS] = '{8'd18, 8'd120, 8'd230, 8'd245,
                                                   8'd235, 8'd145, 8'd30, 8'd4};
  localparam logic [CH_W-1:0] STOP_BLU [STOPS] = '{8'd59, 8'd240, 8'd200, 8'd60,
                                                   8'd27, 8'd5, 8'd10, 8'd3};

  typedef struct packed {
    logic signed [VAL_W-1:0] val_min;
    logic signed [VAL_W-1:0] val_max;
    logic [RADIUS_W-1:0]     radius;
  } cfg_t;

  // after clamp and range set-up
  typedef struct packed {
    logic                has_value;
    logic [VAL_W-1:0]    t_num;
    logic [VAL_W-1:0]    t_den;
    logic                far;
    logic [DIST_W-1:0]   near_dist;
    logic [RADIUS_W-1:0] radius;
  } front_t;

  // state carried through the divider stages
  typedef struct packed {
    logic              has_value;
    logic              far;
    logic [T_W-1:0]    t_rem;
    logic [VAL_W-1:0]  t_den;
    logic [T_W-1:0]    t_quo;
    logic [NUM_W-1:0]  a_rem;
    logic [DSH_W-1:0]  a_dsh;
    logic [CH_W-1:0]   a_quo;
  } div_t;

endpackage

// ===== rtl/core/hvc_front.sv =====
// Input stages: clamp, range set-up and opacity dividend
module hvc_front import hvc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    has_value_i,
  input  logic signed [VAL_W-1:0] pixel_value_i,
  input  logic [DIST_W-1:0]       nearest_dist_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output div_t                    out_data_o
);

  logic   a_valid_q, a_ready;
  front_t a_d, a_q;
  logic   b_valid_q;
  div_t   b_d, b_q;

  logic                    empty;
  logic signed [VAL_W-1:0] v_clamp;
  logic signed [VAL_W:0]   num_wide, den_wide;
  logic [32:0]             r420, d315, n_wide;
  logic [DIST_W-1:0]       two_r;

  // stage A: clamp and range
  always_comb begin
    empty = (cfg_i.val_max <= cfg_i.val_min);
    if (pixel_value_i < cfg_i.val_min) begin
      v_clamp = cfg_i.val_min;
    end else if (pixel_value_i > cfg_i.val_max) begin
      v_clamp = cfg_i.val_max;
    end else begin
      v_clamp = pixel_value_i;
    end
    num_wide = {v_clamp[VAL_W-1], v_clamp} - {cfg_i.val_min[VAL_W-1], cfg_i.val_min};
    den_wide = {cfg_i.val_max[VAL_W-1], cfg_i.val_max} - {cfg_i.val_min[VAL_W-1], cfg_i.val_min};
    a_d.has_value = has_value_i;
    a_d.t_num     = empty ? '0 : num_wide[VAL_W-1:0];
    a_d.t_den     = empty ? VAL_W'(1) : den_wide[VAL_W-1:0];
    a_d.far       = (cfg_i.radius == '0) || (nearest_dist_i >= {1'b0, cfg_i.radius});
    a_d.near_dist = nearest_dist_i;
    a_d.radius    = cfg_i.radius;
  end

  // stage B: opacity dividend 420r - 315d, divisor 2r aligned to the top quotient bit
  always_comb begin
    r420   = 33'(a_q.radius) * 33'd420;
    d315   = 33'(a_q.near_dist) * 33'd315;
    n_wide = r420 - d315;
    two_r  = {a_q.radius, 1'b0};
    b_d.has_value = a_q.has_value;
    b_d.far       = a_q.far;
    b_d.t_rem     = {1'b0, a_q.t_num};
    b_d.t_den     = a_q.t_den;
    b_d.t_quo     = '0;
    b_d.a_rem     = a_q.far ? '0 : n_wide[NUM_W-1:0];
    b_d.a_dsh     = {two_r, 16'b0};
    b_d.a_quo     = '0;
  end

  assign a_ready    = !b_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (a_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= a_d;
    end
    if (a_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_data_o  = b_q;

endmodule

// ===== rtl/core/hvc_div_step.sv =====
// One restoring-division stage: a quotient bit each for t and for opacity
module hvc_div_step import hvc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  div_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output div_t out_data_o
);

  logic             valid_q;
  div_t             data_d, data_q;
  logic             t_ge, a_ge;
  logic [T_W-1:0]   t_sub;
  logic [NUM_W-1:0] a_sub;

  always_comb begin
    // partial remainder stays below twice the divisor, so one compare does
    t_ge  = in_data_i.t_rem >= {1'b0, in_data_i.t_den};
    t_sub = t_ge ? (in_data_i.t_rem - {1'b0, in_data_i.t_den}) : in_data_i.t_rem;
    a_ge  = {8'b0, in_data_i.a_rem} >= in_data_i.a_dsh;
    a_sub = a_ge ? (in_data_i.a_rem - in_data_i.a_dsh[NUM_W-1:0]) : in_data_i.a_rem;

    data_d       = in_data_i;
    data_d.t_rem = {t_sub[T_W-2:0], 1'b0};
    data_d.t_quo = {in_data_i.t_quo[T_W-2:0], t_ge};
    data_d.a_rem = a_sub;
    data_d.a_dsh = {1'b0, in_data_i.a_dsh[DSH_W-1:1]};
    data_d.a_quo = {in_data_i.a_quo[CH_W-2:0], a_ge};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/core/hvc_colour.sv =====
// Output stages: segment pick, channel interpolation and result register
module hvc_colour import hvc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  div_t            in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CH_W-1:0] red_o,
  output logic [CH_W-1:0] green_o,
  output logic [CH_W-1:0] blue_o,
  output logic [CH_W-1:0] opacity_o
);

  // stage 1: segment and offset into it
  logic            s1_valid_q, s1_ready;
  logic            s1_hv_d, s1_hv_q;
  logic [2:0]      s1_seg_d, s1_seg_q;
  logic [17:0]     s1_num_d, s1_num_q;
  logic [CH_W-1:0] s1_alpha_d, s1_alpha_q;
  logic [20:0]     t20, seg_base;

  always_comb begin
    t20 = {in_data_i.t_quo, 4'b0} + {2'b0, in_data_i.t_quo, 2'b0};
    s1_seg_d = 3'd7;
    for (int i = STOPS - 1; i >= 1; i--) begin
      if (t20 <= {STOP_POS[i], 16'b0}) begin
        s1_seg_d = 3'(i);
      end
    end
    seg_base   = {STOP_POS[s1_seg_d - 3'd1], 16'b0};
    s1_num_d   = 18'(t20 - seg_base);
    s1_hv_d    = in_data_i.has_value;
    s1_alpha_d = in_data_i.far ? ALPHA_FAR : in_data_i.a_quo;
  end

  // stage 2: slope times offset per channel
  logic                   s2_valid_q, s2_ready;
  logic                   s2_hv_q, s2_wide3_d, s2_wide3_q;
  logic [CH_W-1:0]        s2_alpha_q;
  logic [CH_W-1:0]        s2_base_d [3];
  logic [CH_W-1:0]        s2_base_q [3];
  logic signed [27:0]     s2_prod_d [3];
  logic signed [27:0]     s2_prod_q [3];
  logic [CH_W-1:0]        c_lo [3];
  logic [CH_W-1:0]        c_hi [3];
  logic signed [CH_W:0]   slope [3];
  logic [2:0]             seg_lo;

  always_comb begin
    seg_lo  = s1_seg_q - 3'd1;
    c_lo[0] = STOP_RED[seg_lo];
    c_lo[1] = STOP_GRN[seg_lo];
    c_lo[2] = STOP_BLU[seg_lo];
    c_hi[0] = STOP_RED[s1_seg_q];
    c_hi[1] = STOP_GRN[s1_seg_q];
    c_hi[2] = STOP_BLU[s1_seg_q];
    s2_wide3_d = (STOP_POS[s1_seg_q] - STOP_POS[seg_lo]) == 5'd3;
    for (int c = 0; c < 3; c++) begin
      slope[c]     = $signed({1'b0, c_hi[c]}) - $signed({1'b0, c_lo[c]});
      s2_prod_d[c] = slope[c] * $signed({1'b0, s1_num_q});
      s2_base_d[c] = c_lo[c];
    end
  end

  // stage 3: floor divide by segment length, add base, zero when no value
  logic               s3_valid_q;
  logic [CH_W-1:0]    s3_ch_d [3];
  logic [CH_W-1:0]    s3_ch_q [3];
  logic [CH_W-1:0]    s3_alpha_d, s3_alpha_q;
  logic [10:0]        y3 [3];
  logic [10:0]        z3 [3];
  logic [26:0]        zq [3];
  logic [10:0]        q3 [3];
  logic [10:0]        quo [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // floor(x / 3) for small signed x via offset and reciprocal
      y3[c]  = s2_prod_q[c][26:16];
      z3[c]  = y3[c] + 11'd768;
      zq[c]  = 27'(z3[c]) * 27'd43691;
      q3[c]  = {1'b0, zq[c][26:17]} - 11'd256;
      quo[c] = s2_wide3_q ? q3[c] : s2_prod_q[c][27:17];
      s3_ch_d[c] = s2_hv_q ? (s2_base_q[c] + quo[c][CH_W-1:0]) : '0;
    end
    s3_alpha_d = s2_hv_q ? s2_alpha_q : '0;
  end

  assign s2_ready   = !s3_valid_q || out_ready_i;
  assign s1_ready   = !s2_valid_q || s2_ready;
  assign in_ready_o = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s2_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_hv_q    <= s1_hv_d;
      s1_seg_q   <= s1_seg_d;
      s1_num_q   <= s1_num_d;
      s1_alpha_q <= s1_alpha_d;
    end
    if (s1_ready && s1_valid_q) begin
      s2_hv_q    <= s1_hv_q;
      s2_wide3_q <= s2_wide3_d;
      s2_alpha_q <= s1_alpha_q;
      s2_base_q  <= s2_base_d;
      s2_prod_q  <= s2_prod_d;
    end
    if (s2_ready && s2_valid_q) begin
      s3_ch_q    <= s3_ch_d;
      s3_alpha_q <= s3_alpha_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign red_o       = s3_ch_q[0];
  assign green_o     = s3_ch_q[1];
  assign blue_o      = s3_ch_q[2];
  assign opacity_o   = s3_alpha_q;

endmodule

// ===== rtl/core/heat_value_colorizer_unit.sv =====
// Heat value colouriser top level: registers, pipeline chain and ports
//
// Maps one pixel per clock to RGBA: the value is clamped to the configured
// range, turned into a Q1.16 fraction and interpolated over an 8-stop colour
// ramp; opacity falls with distance to the nearest sample. A new pixel is
// taken every cycle while in_stall_o is low. A result passes through 22
// register stages (two input stages, 17 long-division stages giving one
// quotient bit each, three colour stages) and is held on the outputs while
// the output is stalled. Stalls backpressure stage by stage, so empty
// stages keep filling while a result waits. Configuration writes are always
// ready and apply to pixels taken after them; write only while the pipeline
// is empty.
module heat_value_colorizer_unit import hvc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    has_value_i,
  input  logic signed [VAL_W-1:0] pixel_value_i,
  input  logic [DIST_W-1:0]       nearest_dist_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [CH_W-1:0]         red_o,
  output logic [CH_W-1:0]         green_o,
  output logic [CH_W-1:0]         blue_o,
  output logic [CH_W-1:0]         opacity_o
);

  cfg_t cfg_q;
  logic front_ready;

  div_t div_data  [DIV_STEPS+1];
  logic div_valid [DIV_STEPS+1];
  logic div_ready [DIV_STEPS+1];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.val_min <= VAL_MIN_RST;
      cfg_q.val_max <= VAL_MAX_RST;
      cfg_q.radius  <= RADIUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_VAL_MIN: cfg_q.val_min <= cfg_data_i[VAL_W-1:0];
        CFG_VAL_MAX: cfg_q.val_max <= cfg_data_i[VAL_W-1:0];
        CFG_RADIUS:  cfg_q.radius  <= cfg_data_i[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  hvc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (front_ready),
    .has_value_i    (has_value_i),
    .pixel_value_i  (pixel_value_i),
    .nearest_dist_i (nearest_dist_i),
    .out_valid_o    (div_valid[0]),
    .out_ready_i    (div_ready[0]),
    .out_data_o     (div_data[0])
  );

  assign in_stall_o = !front_ready;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    hvc_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (div_valid[s]),
      .in_ready_o  (div_ready[s]),
      .in_data_i   (div_data[s]),
      .out_valid_o (div_valid[s+1]),
      .out_ready_i (div_ready[s+1]),
      .out_data_o  (div_data[s+1])
    );
  end

  hvc_colour u_colour (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid[DIV_STEPS]),
    .in_ready_o  (div_ready[DIV_STEPS]),
    .in_data_i   (div_data[DIV_STEPS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .opacity_o   (opacity_o)
  );

endmodule

// ===== rtl/core/hvc_checker.sv =====
// Port-level checks of the heat value colouriser, bound to the top level
`include "heat_value_colorizer_unit_assert.svh"

module hvc_checker import hvc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [CH_W-1:0] red_o,
  input logic [CH_W-1:0] green_o,
  input logic [CH_W-1:0] blue_o,
  input logic [CH_W-1:0] opacity_o
);

  // zero opacity only comes from a pixel with no value, which is black
  `HVC_ASSERT(a_no_value_black, clk_i, rst_ni,
    out_valid_o && (opacity_o == '0) |-> (red_o == '0) && (green_o == '0) && (blue_o == '0))

  // a pixel with a value never gets opacity below the far-field floor or above 210
  `HVC_ASSERT(a_opacity_range, clk_i, rst_ni,
    out_valid_o && (opacity_o != '0) |-> (opacity_o >= ALPHA_FAR) && (opacity_o <= 8'd210))

  `HVC_ASSERT(a_out_held, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_o) && $stable(opacity_o))

  // pipeline comes out of reset empty
  `HVC_ASSERT_ALWAYS(a_empty_after_reset, clk_i,
    $rose(rst_ni) |-> !out_valid_o)

endmodule

bind heat_value_colorizer_unit hvc_checker u_hvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o),
  .opacity_o   (opacity_o)
);
